// ===== hw/rtl/lds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_pkg
// Shared constants, types and codes of the LED scan refresh block.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int CHANNELS           = 16;
  localparam int CHAN_W             = 4;
  localparam int ROW_W              = 4;
  localparam int BANK_SIZE          = 256;
  localparam int MEM_DEPTH          = 2 * BANK_SIZE;
  localparam int MEM_AW             = 9;
  localparam int PIX_W              = 16;
  localparam int ADDR_W             = 8;
  localparam int LVL_W              = 7;
  localparam int CNT_W              = 7;
  localparam int CHUNK_W            = 64;
  localparam int CIDX_W             = 2;
  localparam int IN_TDATA_W         = 24;
  localparam int OUT_TDATA_W        = 72;
  localparam int CFG_AW             = 3;
  localparam int CFG_DW             = 32;

  localparam int BANK_ROWS_DEF      = 16;
  localparam int REFRESH_PERIOD_DEF = 128;

  localparam logic [LVL_W-1:0]  LVL_RESET   = 7'd64;
  localparam logic [7:0]        TMGRST_BYTE = 8'h02;
  localparam logic [CIDX_W-1:0] LAST_CHUNK  = 2'd3;

  localparam logic OP_LATCH = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic REG_GLOBAL_BRIGHTNESS = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_STAGE = 4'b0100,
    ST_SEND  = 4'b1000
  } lds_state_t;

  typedef struct packed {
    logic              clr_we;
    logic [MEM_AW-1:0] clr_addr;
    logic              pix_we;
    logic              rd_en;
    logic [CHAN_W-1:0] rd_chan;
    logic              cap_en;
    logic [CHAN_W-1:0] cap_chan;
    logic              latch_lvl;
    logic              commit;
    logic              load_out;
    logic              out_kind;
    logic [CIDX_W-1:0] out_chunk;
  } lds_cmd_t;

endpackage

// ===== hw/rtl/lds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_ctrl
// Sequencer: memory clear, input handshake, row staging, chunk output.
// ----------------------------------------------------------------------------
module lds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_op,
  output logic             out_tvalid,
  input  logic             out_tready,
  output lds_pkg::lds_cmd_t cmd
);
  import lds_pkg::*;

  lds_state_t          state_r, state_nxt;
  logic [MEM_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CHAN_W:0]     stg_cnt_r, stg_cnt_nxt;
  logic [CIDX_W-1:0]   chunk_r, chunk_nxt;
  logic                kind_r, kind_nxt;
  logic                ctl_r, ctl_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    cmd         = '0;
    in_tready   = 1'b0;
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    stg_cnt_nxt = stg_cnt_r;
    chunk_nxt   = chunk_r;
    kind_nxt    = kind_r;
    ctl_nxt     = ctl_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we   = 1'b1;
        cmd.clr_addr = clr_cnt_r;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_WRITE) begin
            cmd.pix_we = 1'b1;
          end else if (!ctl_r) begin
            kind_nxt  = 1'b0;
            chunk_nxt = '0;
            ctl_nxt   = 1'b1;
            state_nxt = ST_SEND;
          end else begin
            cmd.latch_lvl = 1'b1;
            kind_nxt      = 1'b1;
            chunk_nxt     = '0;
            ctl_nxt       = 1'b0;
            stg_cnt_nxt   = '0;
            state_nxt     = ST_STAGE;
          end
        end
      end
      ST_STAGE: begin
        cmd.rd_en    = ~stg_cnt_r[CHAN_W];
        cmd.rd_chan  = stg_cnt_r[CHAN_W-1:0];
        cmd.cap_en   = (stg_cnt_r != '0);
        cmd.cap_chan = CHAN_W'(stg_cnt_r - 1'b1);
        stg_cnt_nxt  = stg_cnt_r + 1'b1;
        if (stg_cnt_r[CHAN_W]) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          cmd.out_kind  = kind_r;
          cmd.out_chunk = chunk_r;
          chunk_nxt     = chunk_r + 1'b1;
          if (chunk_r == LAST_CHUNK) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      stg_cnt_r   <= '0;
      chunk_r     <= '0;
      kind_r      <= 1'b0;
      ctl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      stg_cnt_r   <= stg_cnt_nxt;
      chunk_r     <= chunk_nxt;
      kind_r      <= kind_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/lds_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_dp
// Datapath: pixel memory, staged row, refresh state, config and output word.
// ----------------------------------------------------------------------------
module lds_dp #(
  parameter int BANK_ROWS      = lds_pkg::BANK_ROWS_DEF,
  parameter int REFRESH_PERIOD = lds_pkg::REFRESH_PERIOD_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lds_pkg::lds_cmd_t            cmd,
  input  logic [lds_pkg::ADDR_W-1:0]   in_addr,
  input  logic [lds_pkg::PIX_W-1:0]    in_value,
  input  logic                         cfg_we,
  input  logic                         cfg_sel,
  input  logic [lds_pkg::LVL_W-1:0]    cfg_wdata,
  output logic [lds_pkg::CFG_DW-1:0]   cfg_rdata,
  output logic                         out_cmd,
  output logic [lds_pkg::CIDX_W-1:0]   out_chunk,
  output logic [lds_pkg::CHUNK_W-1:0]  out_data,
  output logic                         out_done
);
  import lds_pkg::*;

  logic [LVL_W-1:0]  gb_r;
  logic [LVL_W-1:0]  staged_lvl_r;
  logic [LVL_W-1:0]  send_lvl_r;
  logic [PIX_W-1:0]  staged_r [CHANNELS];
  logic [CNT_W-1:0]  count_r;
  logic [ROW_W-1:0]  row_r;
  logic              front_r;
  logic              done_r;
  logic              wrap;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [MEM_AW-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;

  logic [CHANNELS*LVL_W-1:0] dc_field;
  logic [CHUNK_W-1:0]        chunk_data;

  assign ram_we    = cmd.clr_we | cmd.pix_we;
  assign ram_waddr = cmd.clr_we ? cmd.clr_addr : {~front_r, in_addr};
  assign ram_wdata = cmd.clr_we ? '0 : in_value;
  assign ram_raddr = {front_r, row_r, cmd.rd_chan};

  lds_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_pix_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wrap = (count_r == CNT_W'(REFRESH_PERIOD - 1));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gb_r <= LVL_RESET;
    end else if (cfg_we && (cfg_sel == REG_GLOBAL_BRIGHTNESS)) begin
      gb_r <= cfg_wdata;
    end
  end

  assign cfg_rdata = (cfg_sel == REG_GLOBAL_BRIGHTNESS) ? CFG_DW'(gb_r) : '0;

  // staging and refresh state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        staged_r[i] <= '0;
      end
      staged_lvl_r <= LVL_RESET;
      count_r      <= '0;
      row_r        <= '0;
      front_r      <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      if (cmd.cap_en) begin
        staged_r[cmd.cap_chan] <= ram_rdata;
      end
      if (cmd.commit) begin
        staged_lvl_r <= gb_r;
        done_r       <= wrap;
        if (wrap) begin
          count_r <= '0;
          row_r   <= '0;
          front_r <= ~front_r;
        end else begin
          count_r <= count_r + 1'b1;
          row_r   <= (row_r == ROW_W'(BANK_ROWS - 1)) ? '0 : row_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_lvl) begin
      send_lvl_r <= staged_lvl_r;
    end
  end

  // chunk assembly
  assign dc_field = {CHANNELS{send_lvl_r}};

  always_comb begin
    chunk_data = '0;
    if (!cmd.out_kind) begin
      unique case (cmd.out_chunk)
        2'd0:    chunk_data = {staged_r[0],  staged_r[1],  staged_r[2],  staged_r[3]};
        2'd1:    chunk_data = {staged_r[4],  staged_r[5],  staged_r[6],  staged_r[7]};
        2'd2:    chunk_data = {staged_r[8],  staged_r[9],  staged_r[10], staged_r[11]};
        default: chunk_data = {staged_r[12], staged_r[13], staged_r[14], staged_r[15]};
      endcase
    end else begin
      unique case (cmd.out_chunk)
        2'd0, 2'd1: chunk_data = '0;
        2'd2:       chunk_data = {TMGRST_BYTE, 1'b0, send_lvl_r,
                                  dc_field[CHANNELS*LVL_W-1:CHUNK_W]};
        default:    chunk_data = dc_field[CHUNK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cmd   <= cmd.out_kind;
      out_chunk <= cmd.out_chunk;
      out_data  <= chunk_data;
      out_done  <= cmd.out_kind & (cmd.out_chunk == LAST_CHUNK) & done_r;
    end
  end

endmodule

// ===== hw/rtl/led_driver_scan_refresh.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_driver_scan_refresh
// LED panel scan controller: pixel store, row staging, PWM driver frames.
// ----------------------------------------------------------------------------
// After reset the pixel memory is cleared, one word per cycle, with
// in_tready low; config writes are taken meanwhile. A pixel write leaves
// in_tready high for the next item. A latch tick for a grayscale frame
// gives four output words, one per cycle while out_tready is high. A latch
// tick for a control frame first stages the next bank row: 16 reads
// through the single registered read port of the pixel memory, then gives
// its four words. Items are worked one at a time; the last word of a frame
// may still wait in the output register while the next item is taken.
module led_driver_scan_refresh #(
  parameter int BANK_ROWS      = lds_pkg::BANK_ROWS_DEF,
  parameter int REFRESH_PERIOD = lds_pkg::REFRESH_PERIOD_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] pixel_address, [23:8] pixel_value
  input  logic [lds_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] chunk_index, [65:2] chunk_data, [71:66] zero
  output logic [lds_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] command_bit, [1] frame_done
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lds_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [lds_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [lds_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import lds_pkg::*;

  lds_cmd_t           cmd;
  logic               cfg_we;
  logic               o_cmd;
  logic               o_done;
  logic [CIDX_W-1:0]  o_chunk;
  logic [CHUNK_W-1:0] o_data;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  lds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lds_dp #(
    .BANK_ROWS      (BANK_ROWS),
    .REFRESH_PERIOD (REFRESH_PERIOD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_addr   (in_tdata[ADDR_W-1:0]),
    .in_value  (in_tdata[ADDR_W+PIX_W-1:ADDR_W]),
    .cfg_we    (cfg_we),
    .cfg_sel   (cfg_paddr[CFG_AW-1]),
    .cfg_wdata (cfg_pwdata[LVL_W-1:0]),
    .cfg_rdata (cfg_prdata),
    .out_cmd   (o_cmd),
    .out_chunk (o_chunk),
    .out_data  (o_data),
    .out_done  (o_done)
  );

  assign out_tdata = {{(OUT_TDATA_W - CHUNK_W - CIDX_W){1'b0}}, o_data, o_chunk};
  assign out_tuser = {o_done, o_cmd};
  assign out_tlast = (o_chunk == LAST_CHUNK);

endmodule

// ===== hw/rtl/lds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks of the LED scan refresh block, bound to the top level.
// ----------------------------------------------------------------------------
module lds_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lds_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [1:0]                        out_tuser,
  input logic                              out_tlast
);
  import lds_pkg::*;

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[CIDX_W-1:0] == LAST_CHUNK)))
    else $error("tlast does not match chunk index");

  a_done_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tuser[0])
    else $error("frame done outside last control word");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid &&
      (out_tdata[CIDX_W-1:0] == CIDX_W'($past(out_tdata[CIDX_W-1:0]) + 1'b1)) &&
      (out_tuser[0] == $past(out_tuser[0])))
    else $error("frame words out of sequence");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_LATCH) |=> !in_tready)
    else $error("input taken while a frame is pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled word changed");

endmodule

bind led_driver_scan_refresh lds_checker u_lds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_led_driver_scan_refresh.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_driver_scan_refresh
// Self-checking bench for the LED panel scan controller.
// ----------------------------------------------------------------------------
// Pixel writes and latch ticks go in on the input stream. A scan model in the
// bench tracks the pixel banks, the staged row and the refresh count, and
// queues the four chunk words each latch tick should give. Every output word
// is checked field by field against the oldest queued word. Directed tests
// hit reset frames, brightness extremes and pixel extremes; random phases
// then run 110 items each, with and without idling on either side.
// ----------------------------------------------------------------------------
module tb_led_driver_scan_refresh;
  import lds_pkg::*;

  localparam int BANK_ROWS      = BANK_ROWS_DEF;
  localparam int REFRESH_PERIOD = REFRESH_PERIOD_DEF;
  localparam int SETTLE_CYCLES  = 64;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [CFG_AW-1:0] ADDR_BRIGHTNESS = CFG_AW'(4 * int'(REG_GLOBAL_BRIGHTNESS));
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED   = CFG_AW'(4);

  localparam logic CMD_GRAY = 1'b0;
  localparam logic CMD_CTRL = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CIDX_W-1:0] idx;
    logic [63:0]       data;
    logic              last;
    logic              done;
  } frame_chunk_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // scan model state
  logic [PIX_W-1:0] pix_mem [MEM_DEPTH];
  logic             front_sel;
  logic [CNT_W-1:0] refresh_cnt;
  logic             ctrl_next;
  logic [PIX_W-1:0] row_gray [CHANNELS];
  logic [LVL_W-1:0] row_level;
  logic [LVL_W-1:0] brightness;

  frame_chunk_t pending_chunks [$];
  int           err_cnt      = 0;
  int           cycle_cnt    = 0;
  int           tx_idle_pct  = 0;
  int           rx_stall_pct = 0;

  led_driver_scan_refresh u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    frame_chunk_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chunks.size() == 0) begin
        $display("%0t unexpected word: expected none actual tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        want = pending_chunks.pop_front();
        check_field("command_bit", 64'(want.cmd), 64'(out_tuser[0]));
        check_field("chunk_index", 64'(want.idx), 64'(out_tdata[CIDX_W-1:0]));
        check_field("chunk_data", want.data, out_tdata[CIDX_W +: CHUNK_W]);
        check_field("last_chunk", 64'(want.last), 64'(out_tlast));
        check_field("frame_done", 64'(want.done), 64'(out_tuser[1]));
      end
    end
  end

  function automatic void push_chunk(logic cmd, logic [CIDX_W-1:0] idx, logic [63:0] data,
                                     logic done);
    frame_chunk_t c;
    c.cmd  = cmd;
    c.idx  = idx;
    c.data = data;
    c.last = (idx == LAST_CHUNK);
    c.done = done;
    pending_chunks.push_back(c);
  endfunction

  function automatic void scan_model_step(logic op, logic [ADDR_W-1:0] addr,
                                          logic [PIX_W-1:0] val);
    logic [LVL_W-1:0]          lvl;
    logic [CHANNELS*LVL_W-1:0] dc_field;
    logic                      wrapped;
    int                        row;
    if (op == OP_WRITE) begin
      pix_mem[{~front_sel, addr}] = val;
      return;
    end
    if (!ctrl_next) begin
      for (int k = 0; k < 4; k++)
        push_chunk(CMD_GRAY, CIDX_W'(k),
                   {row_gray[4*k], row_gray[4*k+1], row_gray[4*k+2], row_gray[4*k+3]}, 1'b0);
      ctrl_next = 1'b1;
      return;
    end
    lvl      = row_level;
    dc_field = {CHANNELS{lvl}};
    push_chunk(CMD_CTRL, CIDX_W'(0), 64'd0, 1'b0);
    push_chunk(CMD_CTRL, CIDX_W'(1), 64'd0, 1'b0);
    push_chunk(CMD_CTRL, CIDX_W'(2), {TMGRST_BYTE, 1'b0, lvl, dc_field[111:64]}, 1'b0);
    ctrl_next = 1'b0;
    // stage next row from the front bank
    row = int'(refresh_cnt) % BANK_ROWS;
    for (int ch = 0; ch < CHANNELS; ch++)
      row_gray[ch] = pix_mem[{front_sel, ADDR_W'(row * CHANNELS + ch)}];
    row_level   = brightness;
    refresh_cnt = CNT_W'((int'(refresh_cnt) + 1) % REFRESH_PERIOD);
    wrapped     = (refresh_cnt == '0);
    if (wrapped) front_sel = ~front_sel;
    push_chunk(CMD_CTRL, CIDX_W'(3), dc_field[63:0], wrapped);
  endfunction

  task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [PIX_W-1:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_model_step(op, addr, val);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_BRIGHTNESS) brightness = data[LVL_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_reset_frames();
    send_word(OP_LATCH, '0, '0);
    send_word(OP_LATCH, '0, '0);
  endtask

  task automatic test_config_levels();
    logic [CFG_DW-1:0] levels [4];
    levels = '{32'h7F, 32'hFFFF_FF80, 32'h0000_002A, 32'h0000_0001};
    foreach (levels[i]) begin
      wait_idle();
      write_reg(ADDR_UNMAPPED, $urandom());
      write_reg(ADDR_BRIGHTNESS, levels[i]);
      send_word(OP_LATCH, '0, '0);
      send_word(OP_LATCH, '0, '0);
    end
  endtask

  task automatic test_pixel_extremes();
    send_word(OP_WRITE, 8'd0,   16'hFFFF);
    send_word(OP_WRITE, 8'd255, 16'hFFFF);
    send_word(OP_WRITE, 8'd15,  16'h8000);
    send_word(OP_WRITE, 8'd16,  16'h0001);
    send_word(OP_WRITE, 8'd128, 16'h00FF);
    send_word(OP_WRITE, 8'd240, 16'hFF00);
    send_word(OP_WRITE, 8'd255, 16'h0000);
    send_word(OP_LATCH, 8'd255, 16'hFFFF);
    send_word(OP_LATCH, 8'd0,   16'h0000);
  endtask

  task automatic test_random_scan(input int n_items, input int tx_pct, input int rx_pct,
                                  input logic [CFG_DW-1:0] level);
    logic [PIX_W-1:0] val;
    wait_idle();
    write_reg(ADDR_BRIGHTNESS, level);
    write_reg(ADDR_UNMAPPED, $urandom());
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n_items) begin
      case ($urandom_range(3))
        0:       val = 16'h0000;
        1:       val = 16'hFFFF;
        default: val = PIX_W'($urandom_range(16'hFFFF));
      endcase
      if ($urandom_range(99) < 20)
        send_word(OP_WRITE, ADDR_W'($urandom_range(255)), val);
      else
        send_word(OP_LATCH, ADDR_W'($urandom_range(255)), val);
    end
  endtask

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) pix_mem[i] = '0;
    for (int i = 0; i < CHANNELS; i++) row_gray[i] = '0;
    front_sel   = 1'b0;
    refresh_cnt = '0;
    ctrl_next   = 1'b0;
    row_level   = LVL_RESET;
    brightness  = LVL_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_frames();
    test_config_levels();
    test_pixel_extremes();
    test_random_scan(110, 0,  0,  32'h0000_007F);
    test_random_scan(110, 73, 0,  32'h0000_0000);
    test_random_scan(110, 0,  73, $urandom());
    test_random_scan(110, 23, 23, 32'hFFFF_FF81);

    wait_idle();
    if (err_cnt == 0 && pending_chunks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lds_pkg.sv
hw/rtl/lds_ram.sv
hw/rtl/lds_ctrl.sv
hw/rtl/lds_dp.sv
hw/rtl/led_driver_scan_refresh.sv
hw/rtl/lds_checker.sv
tb/tb_led_driver_scan_refresh.sv
